// ===== rtl/core/gtpa_pkg.sv =====
// Shared types and constants of the tile placement allocator.
// No dependencies; every other file but gtpa_ram imports this package.
package gtpa_pkg;

	// Request operations.
	localparam logic [1:0] OP_PLACE   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_REUSED      = 3'd0;
	localparam logic [2:0] ST_NEW         = 3'd1;
	localparam logic [2:0] ST_AFTER_CLEAR = 3'd2;
	localparam logic [2:0] ST_NO_FIT      = 3'd3;
	localparam logic [2:0] ST_DONE        = 3'd4;
	localparam logic [2:0] ST_BAD_ID      = 3'd5;

	// Configuration register indexes.
	localparam logic REG_GRID_COLUMNS = 1'b0;
	localparam logic REG_GRID_ROWS    = 1'b1;

	// Tile size in pixels.
	localparam int TILE_W = 320;
	localparam int TILE_H = 180;

	// Reciprocals: x/320 = ((x>>6)*52429)>>18, x/180 = ((x>>2)*23302)>>20,
	// exact over the whole 16-bit pixel range.
	localparam int RECIP_W = 52429;
	localparam int RECIP_H = 23302;

	// Footprint of one request in tiles and pixels.
	typedef struct packed {
		logic [7:0]  tiles_wide;
		logic [8:0]  tiles_high;
		logic [16:0] span_x;
		logic [16:0] span_y;
	} footprint_t;

endpackage

// ===== rtl/core/gtpa_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on gtpa_pkg for nothing but keeps the same import style.
interface gtpa_req_if;
	import gtpa_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [21:0] owner_id;
	logic [15:0] image_width;
	logic [15:0] image_height;
	modport source (output valid, operation, owner_id, image_width, image_height,
		input ready);
	modport sink (input valid, operation, owner_id, image_width, image_height,
		output ready);
endinterface

interface gtpa_rsp_if;
	import gtpa_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  tile_column;
	logic [2:0]  tile_row;
	logic [7:0]  tiles_wide;
	logic [8:0]  tiles_high;
	logic [11:0] origin_x;
	logic [10:0] origin_y;
	modport source (output valid, status, tile_column, tile_row, tiles_wide,
		tiles_high, origin_x, origin_y, input ready);
	modport sink (input valid, status, tile_column, tile_row, tiles_wide,
		tiles_high, origin_x, origin_y, output ready);
endinterface

// ===== rtl/core/gtpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtpa_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/gtpa_size.sv =====
// Footprint pipeline: ceiling division of the image size by the tile size
// and the pixel span of the footprint. Three register stages; uses gtpa_pkg.
module gtpa_size (
	input  logic                   clk,
	input  logic [15:0]            image_width,
	input  logic [15:0]            image_height,
	output gtpa_pkg::footprint_t   foot
);
	import gtpa_pkg::*;

	logic [16:0] wide_sum, high_sum;
	logic [10:0] wide_div;
	logic [14:0] high_div;
	logic [26:0] wide_prod_s1;
	logic [29:0] high_prod_s1;
	logic [7:0]  tiles_wide_s2;
	logic [8:0]  tiles_high_s2;
	footprint_t  foot_s3;

	// Ceiling division as floor((x + d - 1) / d); the power-of-two part of
	// the divisor is a shift ahead of the reciprocal multiply.
	assign wide_sum = {1'b0, image_width} + 17'(TILE_W - 1);
	assign high_sum = {1'b0, image_height} + 17'(TILE_H - 1);
	assign wide_div = wide_sum[16:6];
	assign high_div = high_sum[16:2];

	always_ff @(posedge clk) begin
		wide_prod_s1 <= 27'(wide_div) * 27'(RECIP_W);
		high_prod_s1 <= 30'(high_div) * 30'(RECIP_H);
		tiles_wide_s2 <= wide_prod_s1[25:18];
		tiles_high_s2 <= high_prod_s1[28:20];
		foot_s3.tiles_wide <= tiles_wide_s2;
		foot_s3.tiles_high <= tiles_high_s2;
		foot_s3.span_x <= 17'(tiles_wide_s2) * 17'(TILE_W);
		foot_s3.span_y <= 17'(tiles_high_s2) * 17'(TILE_H);
	end

	assign foot = foot_s3;
endmodule

// ===== rtl/core/grid_tile_placement_allocator.sv =====
// Top level of the tile placement allocator: control sequencer, valid bits
// and owner memory. Depends on gtpa_pkg, gtpa_if, gtpa_ram and gtpa_size.
//
//  channel  | direction | beat
//  ---------+-----------+-----------------------------------------------------
//  req      | in        | operation, owner_id, image_width, image_height
//  rsp      | out       | status, tile_column, tile_row, tiles_wide, tiles_high,
//           |           | origin_x, origin_y
//  cfg      | in        | cfg_write, cfg_index, cfg_data (no handshake)
//
// One request is worked on at a time. Clear, unknown and rejected requests go
// straight to the finish state. Release reads and checks each active cell,
// since each owner lookup waits on the owner memory read port. Place runs the
// footprint pipeline states, a read and a check per cell of the reuse scan, a
// check per cell inspected by the first-fit search, a mark per marked cell and
// an origin state; a failed first search clears the active area and repeats it.
// The reset takes effect at once: every cell reads as free by its valid bit.
// A finished beat waits in the result register while the next request is taken.
module grid_tile_placement_allocator #(
	parameter int MAX_GRID   = 8,
	parameter int OWNER_BITS = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	gtpa_req_if.sink   req,
	gtpa_rsp_if.source rsp
);
	import gtpa_pkg::*;

	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_GRID + 1);
	localparam int PW    = CW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FOOT1  = 4'd1;
	localparam logic [3:0] S_FOOT2  = 4'd2;
	localparam logic [3:0] S_FOOT3  = 4'd3;
	localparam logic [3:0] S_RS_RD  = 4'd4;
	localparam logic [3:0] S_RS_CK  = 4'd5;
	localparam logic [3:0] S_FIT    = 4'd6;
	localparam logic [3:0] S_FIT_CK = 4'd7;
	localparam logic [3:0] S_MARK   = 4'd8;
	localparam logic [3:0] S_ORG    = 4'd9;
	localparam logic [3:0] S_REL_RD = 4'd10;
	localparam logic [3:0] S_REL_CK = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;
	localparam logic [3:0] S_FOOT4  = 4'd13;

	// Cell address in row-major order with a row pitch of MAX_GRID.
	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] row,
		input logic [PW-1:0] col);
		return AW'(int'(row) * MAX_GRID + int'(col));
	endfunction

	logic [3:0]            state_q;
	logic [3:0]            cols_q, rows_q;
	logic [CW-1:0]         nc, nr;
	logic [DEPTH-1:0]      valid_q, active_mask;
	logic [OWNER_BITS-1:0] id_q, req_id;
	logic [15:0]           w_q, h_q;
	logic                  pass_q;
	logic [CW-1:0]         r_q, c_q, pr_q, pc_q, dr_q, dc_q;
	logic [CW-1:0]         place_col_q, place_row_q;
	logic [2:0]            res_status_q, res_col_q, res_row_q;
	logic [7:0]            res_tw_q;
	logic [8:0]            res_th_q;
	logic [11:0]           res_ox_q;
	logic [10:0]           res_oy_q;
	logic                  out_valid_q;
	logic [2:0]            out_status_q, out_col_q, out_row_q;
	logic [7:0]            out_tw_q;
	logic [8:0]            out_th_q;
	logic [11:0]           out_ox_q;
	logic [10:0]           out_oy_q;
	footprint_t            foot;
	logic [AW-1:0]         scan_addr, fit_addr;
	logic [OWNER_BITS-1:0] ram_rdata;
	logic                  ram_we, fits_any, owner_hit, req_bad_id;
	logic                  scan_last_col, scan_last_row;
	logic                  fit_last_dc, fit_last_dr, fit_next_pc, fit_next_pr;
	logic [16:0]           off_x, off_y, org_x, org_y;

	// Register values above MAX_GRID saturate.
	assign nc = (int'(cols_q) > MAX_GRID) ? CW'(MAX_GRID) : CW'(cols_q);
	assign nr = (int'(rows_q) > MAX_GRID) ? CW'(MAX_GRID) : CW'(rows_q);

	always_comb begin
		for (int r = 0; r < MAX_GRID; r++) begin
			for (int c = 0; c < MAX_GRID; c++) begin
				active_mask[r * MAX_GRID + c] = (r < int'(nr)) && (c < int'(nc));
			end
		end
	end

	assign req_id    = OWNER_BITS'(req.owner_id);
	assign req_bad_id = (req.operation == OP_PLACE || req.operation == OP_RELEASE) &&
		req_id == '0;
	assign scan_addr = addr_of(PW'(r_q), PW'(c_q));
	assign fit_addr  = addr_of(PW'(pr_q) + PW'(dr_q), PW'(pc_q) + PW'(dc_q));
	assign ram_we    = (state_q == S_MARK);
	assign owner_hit = valid_q[scan_addr] && (ram_rdata == id_q);

	// A position exists only when the footprint fits the active area; a zero
	// footprint dimension then places at the origin tile without marking.
	assign fits_any = (10'(foot.tiles_wide) <= 10'(nc)) && (10'(foot.tiles_high) <= 10'(nr));

	assign scan_last_col = !(PW'(c_q) + PW'(1) < PW'(nc));
	assign scan_last_row = !(PW'(r_q) + PW'(1) < PW'(nr));
	assign fit_last_dc   = !(10'(dc_q) + 10'd1 < 10'(foot.tiles_wide));
	assign fit_last_dr   = !(10'(dr_q) + 10'd1 < 10'(foot.tiles_high));
	assign fit_next_pc   = 10'(pc_q) + 10'd1 + 10'(foot.tiles_wide) <= 10'(nc);
	assign fit_next_pr   = 10'(pr_q) + 10'd1 + 10'(foot.tiles_high) <= 10'(nr);

	// Centring offsets; the span is never below the image size.
	assign off_x = (foot.span_x - {1'b0, w_q}) >> 1;
	assign off_y = (foot.span_y - {1'b0, h_q}) >> 1;
	assign org_x = 17'(17'(place_col_q) * 17'(TILE_W)) + off_x;
	assign org_y = 17'(17'(place_row_q) * 17'(TILE_H)) + off_y;

	gtpa_ram #(
		.WIDTH (OWNER_BITS),
		.DEPTH (DEPTH)
	) u_owner_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fit_addr),
		.wdata (id_q),
		.raddr (scan_addr),
		.rdata (ram_rdata)
	);

	gtpa_size u_size (
		.clk          (clk),
		.image_width  (w_q),
		.image_height (h_q),
		.foot         (foot)
	);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.tile_column = out_col_q;
	assign rsp.tile_row    = out_row_q;
	assign rsp.tiles_wide  = out_tw_q;
	assign rsp.tiles_high  = out_th_q;
	assign rsp.origin_x    = out_ox_q;
	assign rsp.origin_y    = out_oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cols_q      <= 4'd4;
			rows_q      <= 4'd4;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GRID_COLUMNS: cols_q <= cfg_data;
					REG_GRID_ROWS:    rows_q <= cfg_data;
				endcase
			end
			// The finish state reloads the result register itself.
			if (rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						id_q         <= req_id;
						w_q          <= req.image_width;
						h_q          <= req.image_height;
						pass_q       <= 1'b0;
						r_q          <= '0;
						c_q          <= '0;
						res_status_q <= req_bad_id ? ST_BAD_ID : ST_DONE;
						res_col_q    <= '0;
						res_row_q    <= '0;
						res_tw_q     <= '0;
						res_th_q     <= '0;
						res_ox_q     <= '0;
						res_oy_q     <= '0;
						priority if (req_bad_id) begin
							state_q <= S_FIN;
						end else if (req.operation == OP_PLACE) begin
							state_q <= S_FOOT1;
						end else if (req.operation == OP_RELEASE) begin
							state_q <= (nr == '0 || nc == '0) ? S_FIN : S_REL_RD;
						end else if (req.operation == OP_CLEAR) begin
							valid_q <= valid_q & ~active_mask;
							state_q <= S_FIN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FOOT1: state_q <= S_FOOT2;
				S_FOOT2: state_q <= S_FOOT3;
				// The third pipeline stage lands at the end of this cycle.
				S_FOOT3: state_q <= S_FOOT4;
				S_FOOT4: begin
					res_tw_q <= foot.tiles_wide;
					res_th_q <= foot.tiles_high;
					state_q  <= (nr == '0 || nc == '0) ? S_FIT : S_RS_RD;
				end
				S_RS_RD: state_q <= S_RS_CK;
				S_RS_CK: begin
					// The first held cell in row-major order is reused.
					if (owner_hit) begin
						place_col_q  <= c_q;
						place_row_q  <= r_q;
						res_status_q <= ST_REUSED;
						state_q      <= S_ORG;
					end else if (!scan_last_col) begin
						c_q     <= c_q + CW'(1);
						state_q <= S_RS_RD;
					end else if (!scan_last_row) begin
						c_q     <= '0;
						r_q     <= r_q + CW'(1);
						state_q <= S_RS_RD;
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					pr_q <= '0;
					pc_q <= '0;
					dr_q <= '0;
					dc_q <= '0;
					if (fits_any) begin
						if (foot.tiles_wide == '0 || foot.tiles_high == '0) begin
							place_col_q  <= '0;
							place_row_q  <= '0;
							res_status_q <= pass_q ? ST_AFTER_CLEAR : ST_NEW;
							state_q      <= S_ORG;
						end else begin
							state_q <= S_FIT_CK;
						end
					end else if (!pass_q) begin
						valid_q <= valid_q & ~active_mask;
						pass_q  <= 1'b1;
					end else begin
						res_status_q <= ST_NO_FIT;
						state_q      <= S_FIN;
					end
				end
				S_FIT_CK: begin
					if (valid_q[fit_addr]) begin
						// Occupied: move to the next position in row-major order; past the last, clear once or fail.
						dr_q <= '0;
						dc_q <= '0;
						if (fit_next_pc) begin
							pc_q <= pc_q + CW'(1);
						end else if (fit_next_pr) begin
							pc_q <= '0;
							pr_q <= pr_q + CW'(1);
						end else if (!pass_q) begin
							valid_q <= valid_q & ~active_mask;
							pass_q  <= 1'b1;
							state_q <= S_FIT;
						end else begin
							res_status_q <= ST_NO_FIT;
							state_q      <= S_FIN;
						end
					end else if (!fit_last_dc) begin
						dc_q <= dc_q + CW'(1);
					end else if (!fit_last_dr) begin
						dc_q <= '0;
						dr_q <= dr_q + CW'(1);
					end else begin
						dc_q    <= '0;
						dr_q    <= '0;
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					valid_q[fit_addr] <= 1'b1;
					if (!fit_last_dc) begin
						dc_q <= dc_q + CW'(1);
					end else if (!fit_last_dr) begin
						dc_q <= '0;
						dr_q <= dr_q + CW'(1);
					end else begin
						place_col_q  <= pc_q;
						place_row_q  <= pr_q;
						res_status_q <= pass_q ? ST_AFTER_CLEAR : ST_NEW;
						state_q      <= S_ORG;
					end
				end
				S_ORG: begin
					res_col_q <= 3'(place_col_q);
					res_row_q <= 3'(place_row_q);
					res_ox_q  <= org_x[11:0];
					res_oy_q  <= org_y[10:0];
					state_q   <= S_FIN;
				end
				S_REL_RD: state_q <= S_REL_CK;
				S_REL_CK: begin
					if (owner_hit) begin
						valid_q[scan_addr] <= 1'b0;
					end
					if (!scan_last_col) begin
						c_q     <= c_q + CW'(1);
						state_q <= S_REL_RD;
					end else if (!scan_last_row) begin
						c_q     <= '0;
						r_q     <= r_q + CW'(1);
						state_q <= S_REL_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_col_q    <= res_col_q;
						out_row_q    <= res_row_q;
						out_tw_q     <= res_tw_q;
						out_th_q     <= res_th_q;
						out_ox_q     <= res_ox_q;
						out_oy_q     <= res_oy_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Marking only ever claims cells the search has just seen free.
	a_mark_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> !valid_q[fit_addr])
		else $error("marking a cell that is already owned");

	// A candidate position keeps the whole footprint inside the active area.
	a_fit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIT_CK |->
		(10'(pr_q) + 10'(foot.tiles_high) <= 10'(nr)) &&
		(10'(pc_q) + 10'(foot.tiles_wide) <= 10'(nc)))
		else $error("fit position outside the active area");

	// Owner lookups stay inside the active area.
	a_scan_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RS_CK || state_q == S_REL_CK) |-> (r_q < nr) && (c_q < nc))
		else $error("owner scan outside the active area");

	// A finished request waits while the previous beat is still held.
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !rsp.ready) |=> state_q == S_FIN)
		else $error("result register overwritten before it was taken");

endmodule

// ===== tb/grid_tile_placement_allocator_test.sv =====
// Self-checking testbench for grid_tile_placement_allocator.
// Depends on gtpa_pkg and the gtpa_req_if / gtpa_rsp_if channel interfaces.
`timescale 1ns / 1ps

module grid_tile_placement_allocator_test;
	import gtpa_pkg::*;

	localparam int GRID      = 8;
	localparam int LIMIT     = 10000000;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]  operation;
		logic [21:0] owner_id;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [2:0]  tile_column;
		logic [2:0]  tile_row;
		logic [7:0]  tiles_wide;
		logic [8:0]  tiles_high;
		logic [11:0] origin_x;
		logic [10:0] origin_y;
	} placement_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic       cfg_index = 1'b0;
	logic [3:0] cfg_data = 4'd0;

	gtpa_req_if req ();
	gtpa_rsp_if rsp ();

	grid_tile_placement_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Requests waiting to be offered, and placements predicted for accepted beats.
	request_t   pending_requests[$];
	placement_t predicted_placements[$];

	// Shadow copy of the owner grid and the two size registers.
	logic [21:0] shadow_owner[GRID*GRID];
	logic [3:0]  shadow_columns;
	logic [3:0]  shadow_rows;

	int  mismatches = 0;
	int  cycle_count = 0;
	bit  sender_hold = 1'b0;     // set by the sequencer to pause the sender
	bit  want_long_stall = 1'b0; // asks the receiver for one long hold-off
	int  stall_percent = 0;      // receiver stall probability for this phase

	function automatic int active_size(logic [3:0] reg_value);
		return (reg_value > GRID) ? GRID : int'(reg_value);
	endfunction

	function automatic void clear_active_area();
		for (int r = 0; r < active_size(shadow_rows); r++)
			for (int c = 0; c < active_size(shadow_columns); c++)
				shadow_owner[r*GRID + c] = '0;
	endfunction

	// First-fit row-major search for a free rectangle; marks it when found.
	// A zero footprint dimension lets the scan run one position past the edge.
	function automatic bit find_free_rect(logic [21:0] id, int tw, int th,
			output int col, output int row);
		int  nc, nr;
		bit  free_here;
		nc  = active_size(shadow_columns);
		nr  = active_size(shadow_rows);
		col = 0;
		row = 0;
		if (tw > nc + 1 || th > nr + 1)
			return 1'b0;
		for (int r = 0; (r + th <= nr) || (th == 0 && r <= nr); r++) begin
			for (int c = 0; (c + tw <= nc) || (tw == 0 && c <= nc); c++) begin
				free_here = 1'b1;
				for (int dr = 0; dr < th; dr++)
					for (int dc = 0; dc < tw; dc++)
						if (shadow_owner[(r+dr)*GRID + c + dc] != '0)
							free_here = 1'b0;
				if (free_here) begin
					for (int dr = 0; dr < th; dr++)
						for (int dc = 0; dc < tw; dc++)
							shadow_owner[(r+dr)*GRID + c + dc] = id;
					col = c;
					row = r;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Works out the placement result of one accepted request and updates the grid.
	function automatic void predict_placement(request_t rq);
		placement_t  p;
		int unsigned tw, th, ox, oy, w, h;
		int          col, row;
		bit          held;
		p   = '{ST_DONE, 3'd0, 3'd0, 8'd0, 9'd0, 12'd0, 11'd0};
		w   = rq.image_width;
		h   = rq.image_height;
		col = 0;
		row = 0;
		held = 1'b0;
		case (rq.operation)
			OP_PLACE: begin
				if (rq.owner_id == '0) begin
					p.status = ST_BAD_ID;
				end else begin
					tw = (w + TILE_W - 1) / TILE_W;
					th = (h + TILE_H - 1) / TILE_H;
					// Reuse the first cell the owner already holds, row-major.
					for (int r = 0; r < active_size(shadow_rows) && !held; r++)
						for (int c = 0; c < active_size(shadow_columns) && !held; c++)
							if (shadow_owner[r*GRID + c] == rq.owner_id) begin
								held = 1'b1;
								col  = c;
								row  = r;
							end
					if (held)
						p.status = ST_REUSED;
					else if (find_free_rect(rq.owner_id, tw, th, col, row))
						p.status = ST_NEW;
					else begin
						clear_active_area();
						p.status = find_free_rect(rq.owner_id, tw, th, col, row) ?
							ST_AFTER_CLEAR : ST_NO_FIT;
					end
					p.tiles_wide = tw[7:0];
					p.tiles_high = th[8:0];
					if (p.status != ST_NO_FIT) begin
						ox = col*TILE_W + ((TILE_W*tw - w) >> 1);
						oy = row*TILE_H + ((TILE_H*th - h) >> 1);
						p.tile_column = col[2:0];
						p.tile_row    = row[2:0];
						p.origin_x    = ox[11:0];
						p.origin_y    = oy[10:0];
					end
				end
			end
			OP_RELEASE: begin
				if (rq.owner_id == '0)
					p.status = ST_BAD_ID;
				else
					for (int r = 0; r < active_size(shadow_rows); r++)
						for (int c = 0; c < active_size(shadow_columns); c++)
							if (shadow_owner[r*GRID + c] == rq.owner_id)
								shadow_owner[r*GRID + c] = '0;
			end
			OP_CLEAR: clear_active_area();
			default: ;
		endcase
		predicted_placements.push_back(p);
	endfunction

	// Driver: offers pending requests in bursts separated by random gaps. The
	// offered beat is held until accepted, and valid gets one assignment per edge.
	request_t offered;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid        <= 1'b0;
			req.operation    <= OP_PLACE;
			req.owner_id     <= '0;
			req.image_width  <= '0;
			req.image_height <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req.valid && req.ready)
				predict_placement(offered);
			if (!req.valid || req.ready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
				end
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() > 0 && !sender_hold) begin
					offered = pending_requests.pop_front();
					req.operation    <= offered.operation;
					req.owner_id     <= offered.owner_id;
					req.image_width  <= offered.image_width;
					req.image_height <= offered.image_height;
					req.valid        <= 1'b1;
					burst_left--;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls at the phase's rate, plus one long hold-off on request
	// so that the block fills and stalls its request channel.
	int long_stall_left = 0;
	bit long_stall_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (want_long_stall && !long_stall_done) begin
				long_stall_done = 1'b1;
				long_stall_left = 600;
			end
			if (long_stall_left > 0) begin
				long_stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= stall_percent);
			end
		end
	end

	// Monitor: compares every result beat with the oldest prediction.
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (predicted_placements.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d col %0d row %0d",
						rsp.status, rsp.tile_column, rsp.tile_row);
			end else begin
				want = predicted_placements.pop_front();
				if (rsp.status !== want.status || rsp.tile_column !== want.tile_column ||
						rsp.tile_row !== want.tile_row ||
						rsp.tiles_wide !== want.tiles_wide ||
						rsp.tiles_high !== want.tiles_high ||
						rsp.origin_x !== want.origin_x || rsp.origin_y !== want.origin_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected st %0d col %0d row %0d tw %0d th %0d ",
							"ox %0d oy %0d, got st %0d col %0d row %0d tw %0d th %0d ",
							"ox %0d oy %0d"},
							want.status, want.tile_column, want.tile_row, want.tiles_wide,
							want.tiles_high, want.origin_x, want.origin_y,
							rsp.status, rsp.tile_column, rsp.tile_row, rsp.tiles_wide,
							rsp.tiles_high, rsp.origin_x, rsp.origin_y);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("FAIL grid_tile_placement_allocator");
			$finish;
		end
	end

	task automatic write_register(logic idx, logic [3:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_GRID_COLUMNS)
			shadow_columns = value;
		else
			shadow_rows = value;
	endtask

	task automatic queue_request(logic [1:0] op, logic [21:0] id, logic [15:0] w,
			logic [15:0] h);
		request_t rq;
		rq = '{op, id, w, h};
		pending_requests.push_back(rq);
	endtask

	// Random requests: mostly placements from a small owner pool, so that reuse,
	// release and the clear-and-retry path all come up often.
	task automatic queue_random_requests(int count);
		logic [1:0]  op;
		logic [21:0] id;
		logic [15:0] w, h;
		int          pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 62) ? OP_PLACE : (pick < 84) ? OP_RELEASE :
				(pick < 94) ? OP_CLEAR : OP_UNKNOWN;
			pick = $urandom_range(0, 99);
			id = (pick < 85) ? 22'($urandom_range(1, 8)) :
				(pick < 95) ? 22'($urandom) : 22'd0;
			if ($urandom_range(0, 4) == 0) begin
				w = 16'($urandom);
				h = 16'($urandom);
			end else begin
				w = 16'($urandom_range(0, 1300));
				h = 16'($urandom_range(0, 760));
			end
			queue_request(op, id, w, h);
		end
	endtask

	// Lets the sender drain and waits until every predicted result has arrived.
	task automatic drain();
		wait (pending_requests.size() == 0 && !req.valid);
		wait (predicted_placements.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < GRID*GRID; i++)
			shadow_owner[i] = '0;
		shadow_columns = 4'd4;
		shadow_rows    = 4'd4;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset size of four by four.
		queue_request(OP_PLACE, 22'd0, 16'd320, 16'd180);        // rejected id
		queue_request(OP_RELEASE, 22'd0, 16'd0, 16'd0);          // rejected id
		queue_request(OP_UNKNOWN, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);
		queue_request(OP_PLACE, 22'd1, 16'd0, 16'd0);            // zero footprint
		queue_request(OP_PLACE, 22'd2, 16'd320, 16'd180);
		queue_request(OP_PLACE, 22'd2, 16'd640, 16'd360);        // reuse
		queue_request(OP_PLACE, 22'd3, 16'd321, 16'd181);
		queue_request(OP_PLACE, 22'd4, 16'd1, 16'd1);
		queue_request(OP_PLACE, 22'd5, 16'd1280, 16'd720);       // full area, after clear
		queue_request(OP_PLACE, 22'd6, 16'd1281, 16'd10);        // one column too wide
		queue_request(OP_PLACE, 22'h3FFFFF, 16'hFFFF, 16'hFFFF); // far too big
		queue_request(OP_PLACE, 22'h2AAAAA, 16'hAAAA, 16'h0);    // zero height, wide
		queue_request(OP_PLACE, 22'h155555, 16'h5555 & 16'h01FF, 16'h5555 & 16'h01FF);
		queue_request(OP_PLACE, 22'd7, 16'd0, 16'd500);
		queue_request(OP_PLACE, 22'd8, 16'd960, 16'd540);
		queue_request(OP_RELEASE, 22'd8, 16'd0, 16'd0);
		queue_request(OP_RELEASE, 22'h3FFFFF, 16'd0, 16'd0);
		queue_request(OP_PLACE, 22'd9, 16'd319, 16'd179);
		queue_request(OP_CLEAR, 22'd0, 16'd0, 16'd0);
		queue_request(OP_PLACE, 22'd10, 16'd640, 16'd0);
		drain();

		// Random phases over several grid sizes, the extremes among them.
		begin
			logic [3:0] col_set[9] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd0, 4'd3, 4'd8, 4'd5, 4'd2};
			logic [3:0] row_set[9] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2, 4'd3, 4'd6};
			int         stall_set[9] = '{0, 30, 70, 10, 50, 0, 20, 85, 40};
			for (int ph = 0; ph < 9; ph++) begin
				write_register(REG_GRID_COLUMNS, col_set[ph]);
				write_register(REG_GRID_ROWS, row_set[ph]);
				stall_percent = stall_set[ph];
				if (ph == 2)
					want_long_stall = 1'b1;
				queue_random_requests(195);
				if (ph == 5) begin
					// The sender stops until the block has delivered everything.
					wait (pending_requests.size() < 100);
					sender_hold = 1'b1;
					wait (predicted_placements.size() == 0);
					@(posedge clk);
					sender_hold = 1'b0;
				end
				drain();
			end
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && predicted_placements.size() == 0)
			$display("PASS grid_tile_placement_allocator");
		else
			$display("FAIL grid_tile_placement_allocator");
		$finish;
	end

endmodule
